// ===== design/acp_pkg.sv =====
// shared types and constants for the ascii coordinate command parser
package acp_pkg;

	localparam logic [7:0] CharZero  = 8'd48;
	localparam logic [7:0] CharNine  = 8'd57;
	localparam logic [7:0] CharSpace = 8'h20;
	localparam logic [7:0] CharMinus = 8'h2d;
	localparam logic [7:0] CharNul   = 8'h00;

	typedef enum logic [6:0] {
		PH_LEAD = 7'b0000001,
		PH_XDIG = 7'b0000010,
		PH_GAP  = 7'b0000100,
		PH_YDIG = 7'b0001000,
		PH_XNEG = 7'b0010000,
		PH_YNEG = 7'b0100000,
		PH_CMD  = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		ST_FOUND = 2'd0,
		ST_BAD   = 2'd1,
		ST_ENDED = 2'd2
	} status_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] x_acc;
		logic [31:0] y_acc;
		logic [7:0]  kept;
		logic        done;
	} parse_state_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] x_value;
		logic [31:0] y_value;
		logic [7:0]  command;
		status_t     status;
	} parse_result_t;

	localparam parse_state_t StateReset = '{
		phase: PH_LEAD,
		x_acc: 32'd0,
		y_acc: 32'd0,
		kept:  8'd0,
		done:  1'b0
	};

endpackage

// ===== design/acp_step.sv =====
// per-byte next-state and result logic of the parser
module acp_step import acp_pkg::*; (
	input  parse_state_t  cur,
	input  logic [7:0]    char_code,
	input  logic          last,
	output parse_state_t  nxt,
	output parse_result_t res
);

	logic        is_dig;
	logic        is_sp;
	logic        is_min;
	logic        term;
	logic [31:0] digit;
	logic [31:0] x_acc10;
	logic [31:0] y_acc10;
	logic [31:0] x_add;
	logic [31:0] y_add;
	logic [31:0] y_sub;
	logic        hit;
	status_t     st;

	assign is_dig  = char_code inside {[CharZero:CharNine]};
	assign is_sp   = (char_code == CharSpace);
	assign is_min  = (char_code == CharMinus);
	assign term    = (char_code == CharNul) || last;
	assign digit   = {28'd0, char_code[3:0]};
	assign x_acc10 = {cur.x_acc[28:0], 3'b000} + {cur.x_acc[30:0], 1'b0};
	assign y_acc10 = {cur.y_acc[28:0], 3'b000} + {cur.y_acc[30:0], 1'b0};
	assign x_add   = x_acc10 + digit;
	assign y_add   = y_acc10 + digit;
	assign y_sub   = y_acc10 - digit;

	always_comb begin
		nxt = cur;
		hit = 1'b0;
		st  = ST_FOUND;
		if (!cur.done) begin
			if (char_code != CharNul) begin
				case (cur.phase)
					PH_LEAD: begin
						if (is_min) begin
							nxt.phase = PH_XNEG;
						end else if (is_dig) begin
							nxt.phase = PH_XDIG;
							nxt.x_acc = x_add;
						end else if (!is_sp) begin
							nxt.phase = PH_XDIG;
							hit = 1'b1;
							st  = ST_BAD;
						end
					end
					PH_XDIG: begin
						if (is_dig) begin
							nxt.x_acc = x_add;
						end else if (is_sp) begin
							nxt.phase = PH_GAP;
						end else begin
							hit = 1'b1;
							st  = ST_BAD;
						end
					end
					PH_GAP: begin
						if (is_dig) begin
							nxt.phase = PH_YDIG;
							nxt.y_acc = y_add;
						end else if (is_min) begin
							nxt.phase = PH_YNEG;
						end else if (!is_sp) begin
							hit = 1'b1;
							st  = ST_BAD;
						end
					end
					PH_YDIG: begin
						if (is_dig) begin
							nxt.y_acc = y_add;
						end else begin
							nxt.phase = PH_CMD;
							if (!is_sp) begin
								nxt.kept = char_code;
								hit = 1'b1;
							end
						end
					end
					PH_XNEG: begin
						if (is_dig) begin
							nxt.x_acc = x_add;
						end else begin
							nxt.x_acc = 32'd0 - cur.x_acc;
							nxt.phase = PH_GAP;
							if (is_min) begin
								nxt.phase = PH_YNEG;
							end else if (!is_sp) begin
								hit = 1'b1;
								st  = ST_BAD;
							end
						end
					end
					PH_YNEG: begin
						if (is_dig) begin
							nxt.y_acc = y_sub;
						end else begin
							nxt.phase = PH_CMD;
							if (!is_sp) begin
								nxt.kept = char_code;
								hit = 1'b1;
							end
						end
					end
					PH_CMD: begin
						if (!is_sp) begin
							nxt.kept = char_code;
							hit = 1'b1;
						end
					end
					default: begin
						nxt = cur;
					end
				endcase
			end
			if (!hit && term) begin
				if (nxt.phase == PH_XNEG) begin
					nxt.x_acc = 32'd0 - nxt.x_acc;
				end
				if (nxt.phase == PH_CMD) begin
					nxt.kept = 8'd0;
				end
				hit = 1'b1;
				st  = ST_ENDED;
			end
		end

		res.hit     = hit;
		res.x_value = nxt.x_acc;
		res.y_value = nxt.y_acc;
		res.command = nxt.kept;
		res.status  = st;

		// message boundary clears everything but the kept command
		if (term) begin
			nxt.phase = PH_LEAD;
			nxt.x_acc = 32'd0;
			nxt.y_acc = 32'd0;
			nxt.done  = 1'b0;
		end else if (hit) begin
			nxt.done = 1'b1;
		end
	end

endmodule

// ===== design/ascii_coordinate_command_parser_unit.sv =====
// top level of the ascii coordinate command parser
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  input   | in        | in_valid / in_ready  | char_code, last
//  result  | out       | out_valid / out_ready| x_value, y_value, command, status
//
// one byte per cycle while out_ready does not stall a held result; a byte that yields a result
// has it registered in the result register after the input register and the byte logic
// arst_n clears the parse state, the kept command and both valid flags
// a stalled result holds the byte stage, which in turn drops in_ready once it is full
module ascii_coordinate_command_parser_unit import acp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_code,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] x_value,
	output logic signed [31:0] y_value,
	output logic [7:0]         command,
	output logic [1:0]         status
);

	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          last_s1;
	logic          valid_s2;
	logic [31:0]   x_s2;
	logic [31:0]   y_s2;
	logic [7:0]    cmd_s2;
	status_t       status_s2;
	parse_state_t  state_q;
	parse_state_t  state_nxt;
	parse_result_t res;
	logic          advance;

	acp_step u_step (
		.cur       (state_q),
		.char_code (char_s1),
		.last      (last_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateReset;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.hit;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.hit) begin
			x_s2      <= res.x_value;
			y_s2      <= res.y_value;
			cmd_s2    <= res.command;
			status_s2 <= res.status;
		end
	end

	assign out_valid = valid_s2;
	assign x_value   = x_s2;
	assign y_value   = y_s2;
	assign command   = cmd_s2;
	assign status    = status_s2;

endmodule

// ===== verif/tb_ascii_coordinate_command_parser_unit.sv =====
// testbench for the ascii coordinate command parser: directed table, random messages, predictor
`timescale 1ns / 100ps

module tb_ascii_coordinate_command_parser_unit;
	import acp_pkg::*;

	localparam int CycleLimit  = 400000;
	localparam int RandomBytes = 1950;
	localparam int HoldCycles  = 300;
	localparam int DrainCycles = 16;
	localparam int NoResult    = -1;
	localparam int NumDirected = 25;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [7:0]  cmd;
		status_t     st;
	} coord_result_t;

	typedef struct packed {
		logic [7:0]    code;
		logic          lst;
		logic          typed;
		coord_result_t want;
	} stim_row_t;

	localparam coord_result_t NoCheck = '{32'd0, 32'd0, 8'd0, ST_FOUND};

	localparam stim_row_t DirectedRows [NumDirected] = '{
		'{8'h00, 1'b0, 1'b1, '{32'd0, 32'd0, 8'd0, ST_ENDED}},
		'{8'h61, 1'b0, 1'b1, '{32'd0, 32'd0, 8'd0, ST_BAD}},
		'{8'h00, 1'b0, 1'b0, NoCheck},
		'{8'h20, 1'b0, 1'b0, NoCheck},
		'{8'h2d, 1'b0, 1'b0, NoCheck},
		'{8'h39, 1'b0, 1'b0, NoCheck},
		'{8'h20, 1'b0, 1'b0, NoCheck},
		'{8'h2d, 1'b0, 1'b0, NoCheck},
		'{8'h35, 1'b0, 1'b0, NoCheck},
		'{8'h5a, 1'b0, 1'b0, NoCheck},
		'{8'h37, 1'b1, 1'b0, NoCheck},
		'{8'h34, 1'b0, 1'b0, NoCheck},
		'{8'h32, 1'b0, 1'b0, NoCheck},
		'{8'h20, 1'b0, 1'b0, NoCheck},
		'{8'h37, 1'b0, 1'b0, NoCheck},
		'{8'h20, 1'b0, 1'b0, NoCheck},
		'{8'h00, 1'b0, 1'b0, NoCheck},
		'{8'hff, 1'b1, 1'b1, '{32'd0, 32'd0, 8'd0, ST_BAD}},
		'{8'h31, 1'b0, 1'b0, NoCheck},
		'{8'h20, 1'b0, 1'b0, NoCheck},
		'{8'h32, 1'b0, 1'b0, NoCheck},
		'{8'h2d, 1'b1, 1'b0, NoCheck},
		'{8'h33, 1'b1, 1'b0, NoCheck},
		'{8'h2d, 1'b0, 1'b0, NoCheck},
		'{8'h38, 1'b1, 1'b0, NoCheck}
	};

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         char_code = 8'd0;
	logic               last = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] x_value;
	logic signed [31:0] y_value;
	logic [7:0]         command;
	logic [1:0]         status;

	coord_result_t pending_results [$];
	logic [7:0]    msg_bytes [$];
	int            errors = 0;
	int            cycles = 0;
	int            bytes_sent = 0;
	int            burst_left = 0;
	int            hold_requests = 0;

	phase_t      pr_phase = PH_LEAD;
	logic [31:0] pr_x = 32'd0;
	logic [31:0] pr_y = 32'd0;
	logic [7:0]  pr_kept = 8'd0;
	bit          pr_done = 1'b0;

	ascii_coordinate_command_parser_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.x_value   (x_value),
		.y_value   (y_value),
		.command   (command),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CycleLimit) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	function automatic bit is_digit(logic [7:0] c);
		return c >= CharZero && c <= CharNine;
	endfunction

	// walks the phases for one nonzero byte
	function automatic int scan_byte(logic [7:0] c);
		int k;
		for (k = 0; k < 4; k++) begin
			case (pr_phase)
				PH_LEAD: begin
					if (c == CharSpace) return NoResult;
					if (c == CharMinus) begin
						pr_phase = PH_XNEG;
						return NoResult;
					end
					pr_phase = PH_XDIG;
				end
				PH_XDIG: begin
					if (is_digit(c)) begin
						pr_x = pr_x * 32'd10 + 32'(c - CharZero);
						return NoResult;
					end
					if (c != CharSpace) return int'(ST_BAD);
					pr_phase = PH_GAP;
				end
				PH_GAP: begin
					if (c == CharSpace) return NoResult;
					if (c == CharMinus) begin
						pr_phase = PH_YNEG;
						return NoResult;
					end
					if (!is_digit(c)) return int'(ST_BAD);
					pr_phase = PH_YDIG;
				end
				PH_YDIG: begin
					if (is_digit(c)) begin
						pr_y = pr_y * 32'd10 + 32'(c - CharZero);
						return NoResult;
					end
					pr_phase = PH_CMD;
				end
				PH_XNEG: begin
					if (is_digit(c)) begin
						pr_x = pr_x * 32'd10 + 32'(c - CharZero);
						return NoResult;
					end
					pr_x = 32'd0 - pr_x;
					pr_phase = PH_GAP;
				end
				PH_YNEG: begin
					if (is_digit(c)) begin
						pr_y = pr_y * 32'd10 - 32'(c - CharZero);
						return NoResult;
					end
					pr_phase = PH_CMD;
				end
				PH_CMD: begin
					if (c == CharSpace) return NoResult;
					pr_kept = c;
					return int'(ST_FOUND);
				end
				default: return NoResult;
			endcase
		end
		return NoResult;
	endfunction

	task automatic predict_byte(input logic [7:0] c, input logic l, output bit hit,
			output coord_result_t res);
		bit term;
		int st;
		term = (c == CharNul) || l;
		st = NoResult;
		if (!pr_done) begin
			if (c != CharNul) st = scan_byte(c);
			if (st == NoResult && term) begin
				if (pr_phase == PH_XNEG) pr_x = 32'd0 - pr_x;
				if (pr_phase == PH_CMD) pr_kept = CharNul;
				st = int'(ST_ENDED);
			end
		end
		hit = (st != NoResult);
		res.x = pr_x;
		res.y = pr_y;
		res.cmd = pr_kept;
		res.st = hit ? status_t'(st[1:0]) : ST_FOUND;
		if (term) begin
			pr_phase = PH_LEAD;
			pr_x = 32'd0;
			pr_y = 32'd0;
			pr_done = 1'b0;
		end else if (hit) begin
			pr_done = 1'b1;
		end
	endtask

	// offers one byte and returns at the edge where the transaction happens
	task automatic send_byte(input logic [7:0] c, input logic l, output bit hit,
			output coord_result_t res);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 48);
		end
		in_valid <= 1'b1;
		char_code <= c;
		last <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		bytes_sent++;
		predict_byte(c, l, hit, res);
	endtask

	task automatic send_predicted(input logic [7:0] c, input logic l);
		bit hit;
		coord_result_t res;
		send_byte(c, l, hit, res);
		if (hit) pending_results.push_back(res);
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	function automatic void push_digits(int n);
		repeat (n) msg_bytes.push_back(8'($urandom_range(48, 57)));
	endfunction

	function automatic void push_spaces(int n);
		repeat (n) msg_bytes.push_back(CharSpace);
	endfunction

	function automatic int digit_count();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
	endfunction

	task automatic build_message(output bit use_last);
		int kind;
		int cut;
		logic [7:0] c;
		msg_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 90) begin
			push_spaces($urandom_range(0, 2));
			if ($urandom_range(0, 1)) msg_bytes.push_back(CharMinus);
			push_digits(digit_count());
			push_spaces($urandom_range(1, 2));
			if ($urandom_range(0, 1)) msg_bytes.push_back(CharMinus);
			push_digits(digit_count());
			push_spaces($urandom_range(0, 2));
			c = 8'($urandom_range(1, 255));
			if (c == CharSpace) c = 8'h21;
			msg_bytes.push_back(c);
			repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom_range(1, 255)));
			if (kind >= 65 && kind < 80) begin
				cut = $urandom_range(0, msg_bytes.size() - 1);
				while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
			end else if (kind >= 80) begin
				cut = $urandom_range(0, msg_bytes.size() - 1);
				msg_bytes[cut] = 8'($urandom_range(0, 255));
			end
		end else begin
			repeat ($urandom_range(1, 10)) msg_bytes.push_back(8'($urandom_range(0, 255)));
		end
		use_last = (msg_bytes.size() != 0) && ($urandom_range(0, 1) == 1);
		if (!use_last) begin
			msg_bytes.push_back(CharNul);
			use_last = ($urandom_range(0, 3) == 0);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	initial begin
		coord_result_t want;
		int hold_left;
		int hold_seen;
		int mode;
		int rx_cycle;
		hold_left = 0;
		hold_seen = 0;
		mode = 0;
		rx_cycle = 0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t unexpected result: expected none actual %h %h %h %h",
						$time, x_value, y_value, command, status);
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("x_value", want.x, x_value);
					check_field("y_value", want.y, y_value);
					check_field("command", 32'(want.cmd), 32'(command));
					check_field("status", 32'(want.st), 32'(status));
				end
			end
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = HoldCycles;
			end
			if (rx_cycle % 256 == 0) mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= ($urandom_range(0, 9) < 4);
					default: out_ready <= (rx_cycle % 8 != 0);
				endcase
			end
		end
	end

	initial begin
		bit hit;
		bit use_last;
		bit hold_done;
		bit pause_done;
		coord_result_t res;
		int i;
		hold_done = 1'b0;
		pause_done = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (i = 0; i < NumDirected; i++) begin
			send_byte(DirectedRows[i].code, DirectedRows[i].lst, hit, res);
			if (hit) pending_results.push_back(DirectedRows[i].typed ? DirectedRows[i].want : res);
		end
		wait_results_drained();

		bytes_sent = 0;
		while (bytes_sent < RandomBytes) begin
			if (!hold_done && bytes_sent > 600) begin
				hold_requests++;
				hold_done = 1'b1;
			end
			if (!pause_done && bytes_sent > 1300) begin
				wait_results_drained();
				pause_done = 1'b1;
			end
			build_message(use_last);
			for (i = 0; i < msg_bytes.size(); i++)
				send_predicted(msg_bytes[i], use_last && (i == msg_bytes.size() - 1));
		end

		wait_results_drained();
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/acp_pkg.sv
design/acp_step.sv
design/ascii_coordinate_command_parser_unit.sv
verif/tb_ascii_coordinate_command_parser_unit.sv
